// ----- design/rpfsd_pkg.sv -----
// Package for the row packet frame store: constants, payload types and the dot decoder.
package rpfsd_pkg;

  // Frame geometry and packet layout.
  localparam int ROW_BYTES      = 16;
  localparam int FRAME_BYTES    = 1024;
  localparam int PACKET_BYTES   = 19;
  localparam int LAST_ROW_START = 1008;
  localparam int HEADER_BYTES   = 3;
  localparam int ROW_COUNT      = FRAME_BYTES / ROW_BYTES;
  localparam int LAST_ROW       = LAST_ROW_START / ROW_BYTES;
  localparam int COL_W          = $clog2(ROW_BYTES);
  localparam int ROW_IDX_W      = $clog2(ROW_COUNT);
  localparam int POS_W          = $clog2(PACKET_BYTES + 1);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // Framing bytes.
  localparam logic [7:0] START_BYTE  = 8'h59;
  localparam logic [7:0] SECOND_BYTE = 8'h32;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Dither phase runs 0, 1, 2 and wraps.
  localparam logic [1:0] PHASE_LAST = 2'd2;

  // Input item modes.
  localparam logic [1:0] MODE_RX    = 2'd0;
  localparam logic [1:0] MODE_SCAN  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  typedef logic [ROW_BYTES-1:0][7:0] row_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [9:0] scan_index;
  } in_word_t;

  typedef struct packed {
    logic [3:0] dots;
    logic [5:0] pixel_x;
    logic [5:0] pixel_y;
    logic       linked;
    logic       row_done;
    logic [5:0] row_written;
  } out_word_t;

  // Work handed from the deframer to the execution side.
  typedef enum logic [1:0] {
    CMD_PLAIN,
    CMD_ROW,
    CMD_SCAN,
    CMD_FRAME
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic                  linked;
    logic [ROW_IDX_W-1:0]  row;
    logic [9:0]            scan_index;
    row_t                  row_data;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

  // Four 2-bit grey pixels to dark dots under the current dither phase.
  function automatic logic [3:0] dots_of(input logic [7:0] v, input logic [1:0] phase);
    logic [3:0] d;
    logic       a;
    logic       b;
    d = '0;
    for (int i = 0; i < 4; i++) begin
      a = v[7 - 2 * i];
      b = v[6 - 2 * i];
      case ({a, b})
        2'b00:   d[i] = 1'b1;
        2'b10:   d[i] = (phase != 2'd0);
        2'b01:   d[i] = (phase == 2'd0);
        default: d[i] = 1'b0;
      endcase
    end
    return d;
  endfunction

endpackage

// ----- design/rpfsd_front.sv -----
// Deframer: hunts packets, stages pixel bytes and classifies every input word.
module rpfsd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpfsd_pkg::in_word_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output rpfsd_pkg::cmd_t    push_data
);

  logic [rpfsd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                  held_r, held_nxt;
  rpfsd_pkg::row_t             staging_r, staging_nxt;
  logic                        link_r, link_nxt;
  logic                        accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    logic [rpfsd_pkg::POS_W-1:0] pos_eff;
    logic [rpfsd_pkg::POS_W-1:0] pos_inc;
    logic [rpfsd_pkg::POS_W-1:0] col;
    pos_eff     = pos_r;
    pos_inc     = pos_r;
    col         = '0;
    pos_nxt     = pos_r;
    held_nxt    = held_r;
    staging_nxt = staging_r;
    link_nxt    = link_r;

    case (in_data.mode)
      rpfsd_pkg::MODE_SCAN:  push_data.kind = rpfsd_pkg::CMD_SCAN;
      rpfsd_pkg::MODE_FRAME: push_data.kind = rpfsd_pkg::CMD_FRAME;
      default:               push_data.kind = rpfsd_pkg::CMD_PLAIN;
    endcase

    if (in_data.mode == rpfsd_pkg::MODE_RX) begin
      // A wrong second byte restarts the hunt and is tried as a start byte.
      if (pos_r == rpfsd_pkg::POS_W'(1) && in_data.rx_byte != rpfsd_pkg::SECOND_BYTE) begin
        pos_eff = '0;
      end
      pos_nxt = pos_eff;
      if (!(pos_eff == '0 && in_data.rx_byte != rpfsd_pkg::START_BYTE)) begin
        col = pos_eff - rpfsd_pkg::POS_W'(rpfsd_pkg::HEADER_BYTES);
        if (pos_eff == rpfsd_pkg::POS_W'(2)) begin
          held_nxt = in_data.rx_byte;
        end else if (pos_eff >= rpfsd_pkg::POS_W'(rpfsd_pkg::HEADER_BYTES) &&
                     pos_eff < rpfsd_pkg::POS_W'(rpfsd_pkg::HEADER_BYTES +
                                                 rpfsd_pkg::ROW_BYTES)) begin
          staging_nxt[col[rpfsd_pkg::COL_W-1:0]] = in_data.rx_byte;
        end
        pos_inc = pos_eff + rpfsd_pkg::POS_W'(1);
        if (pos_inc == rpfsd_pkg::POS_W'(rpfsd_pkg::PACKET_BYTES)) begin
          pos_nxt        = '0;
          link_nxt       = 1'b1;
          push_data.kind = rpfsd_pkg::CMD_ROW;
        end else begin
          pos_nxt = pos_inc;
        end
      end
    end

    push_data.linked     = link_nxt;
    // A row whose start lies past the last row goes to row 0.
    push_data.row        = (held_r > 8'(rpfsd_pkg::LAST_ROW)) ?
                           '0 : held_r[rpfsd_pkg::ROW_IDX_W-1:0];
    push_data.scan_index = in_data.scan_index;
    push_data.row_data   = staging_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      held_r <= '0;
      link_r <= 1'b0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      link_r <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      staging_r <= staging_nxt;
    end
  end

endmodule

// ----- design/rpfsd_queue.sv -----
// Two-entry command queue between the deframer and the execution side.
module rpfsd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  rpfsd_pkg::cmd_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rpfsd_pkg::cmd_t pop_data
);

  rpfsd_pkg::cmd_t              entries_r [rpfsd_pkg::QUEUE_DEPTH];
  logic [rpfsd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rpfsd_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (count_r != rpfsd_pkg::QCNT_W'(rpfsd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + rpfsd_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - rpfsd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + rpfsd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + rpfsd_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/rpfsd_back.sv -----
// Execution side: row-wide frame memory, dither phase, scan decode and the output register.
module rpfsd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  rpfsd_pkg::cmd_t      pop_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rpfsd_pkg::out_word_t out_data
);

  rpfsd_pkg::row_t              mem [rpfsd_pkg::ROW_COUNT];
  logic [rpfsd_pkg::ROW_COUNT-1:0] row_valid_r;
  rpfsd_pkg::row_t              rd_row_r;
  logic                         rd_valid_r;

  rpfsd_pkg::back_state_t       state_r, state_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [9:0]                   scan_idx_r;
  logic                         scan_linked_r;
  logic                         out_valid_r;
  rpfsd_pkg::out_word_t         out_data_r, out_word;

  logic                         out_free, do_pop, mem_we, mem_re, out_load;
  logic [rpfsd_pkg::ROW_IDX_W-1:0] rd_addr;
  logic [7:0]                   scan_byte;

  assign out_free  = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign rd_addr   = pop_data.scan_index[rpfsd_pkg::COL_W +: rpfsd_pkg::ROW_IDX_W];
  assign scan_byte = rd_valid_r ? rd_row_r[scan_idx_r[rpfsd_pkg::COL_W-1:0]]
                                : rpfsd_pkg::ERASED_BYTE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpfsd_pkg::BK_IDLE: begin
        if (do_pop && pop_data.kind == rpfsd_pkg::CMD_SCAN) begin
          state_nxt = rpfsd_pkg::BK_SCAN;
        end
      end
      rpfsd_pkg::BK_SCAN: begin
        if (out_free) begin
          state_nxt = rpfsd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rpfsd_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop_ready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    phase_nxt = phase_r;
    out_word  = '0;
    case (state_r)
      rpfsd_pkg::BK_IDLE: begin
        pop_ready = out_free;
        out_word.linked = pop_data.linked;
        if (do_pop) begin
          case (pop_data.kind)
            rpfsd_pkg::CMD_SCAN: begin
              mem_re = 1'b1;
            end
            rpfsd_pkg::CMD_ROW: begin
              mem_we               = 1'b1;
              out_load             = 1'b1;
              out_word.row_done    = 1'b1;
              out_word.row_written = pop_data.row;
            end
            rpfsd_pkg::CMD_FRAME: begin
              out_load  = 1'b1;
              phase_nxt = (phase_r == rpfsd_pkg::PHASE_LAST) ? 2'd0 : phase_r + 2'd1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      rpfsd_pkg::BK_SCAN: begin
        out_load         = out_free;
        out_word.linked  = scan_linked_r;
        out_word.dots    = rpfsd_pkg::dots_of(scan_byte, phase_r);
        out_word.pixel_x = {scan_idx_r[rpfsd_pkg::COL_W-1:0], 2'b00};
        out_word.pixel_y = scan_idx_r[rpfsd_pkg::COL_W +: rpfsd_pkg::ROW_IDX_W];
      end
      default: begin
        out_word = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpfsd_pkg::BK_IDLE;
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        row_valid_r[pop_data.row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_word;
    end
    if (do_pop) begin
      scan_idx_r    <= pop_data.scan_index;
      scan_linked_r <= pop_data.linked;
    end
  end

  // Frame memory, one 16-byte row per entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pop_data.row] <= pop_data.row_data;
    end
    if (mem_re) begin
      rd_row_r   <= mem[rd_addr];
      rd_valid_r <= row_valid_r[rd_addr];
    end
  end

endmodule

// ----- design/row_packet_frame_store_dither.sv -----
// Top level of the row packet deframer with frame store and dithered scan-out.
//
//   Channel  | Ports                        | Direction | Word
//   ---------+------------------------------+-----------+----------------------------
//   input    | in_valid, in_ready, in_data  | in        | mode, rx_byte, scan_index
//   result   | out_valid, out_ready, out_data | out     | dots, pixel_x, pixel_y,
//            |                              |           | linked, row_done, row_written
//
// Every input word yields exactly one result word, in order.
// A serial byte, a frame-end word or an unused mode goes from the queue straight into the
// output register; a scan first passes the registered read port of the frame memory and the
// scan state. A completed row is written as one 128-bit memory row.
// Reset is synchronous and active low. The frame memory needs no clearing pass: one valid
// flag per row makes an unwritten row read as all ones, so the block is ready at once.
// The deframer and the back end are joined by a two-entry queue, so input words keep
// flowing while a result waits on out_ready; in_ready drops only when the queue is full.
module row_packet_frame_store_dither (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rpfsd_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rpfsd_pkg::out_word_t out_data
);

  // Command path from the deframer into the queue and from the queue to the back end.
  logic            push_valid, push_ready;
  rpfsd_pkg::cmd_t push_data;
  logic            pop_valid, pop_ready;
  rpfsd_pkg::cmd_t pop_data;

  // The front end tracks the packet position, the held row number, the staged pixel bytes
  // and the link flag. It tags every word with what the back end must do.
  rpfsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rpfsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end owns the frame memory and the dither phase, and registers each result.
  rpfsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the row packet deframer, frame store and dithered scan-out.
module tb;

  // The block takes a fourth mode that has no effect; the package leaves it unnamed.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // A scan passes the frame memory's read register and the scan state in the back end and the
  // queue holds two words, so the drain wait is plenty for anything still in flight to show up.
  localparam int DRAIN_CYCLES = 8;

  // Random words per idling phase; four phases give about 1250 words in all.
  localparam int RANDOM_WORDS_PER_PHASE = 312;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  rpfsd_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rpfsd_pkg::out_word_t out_data;

  row_packet_frame_store_dither u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the block's state, advanced once per accepted input word.
  int         rx_position;
  logic [7:0] held_row;
  logic [7:0] staged_row [rpfsd_pkg::ROW_BYTES];
  logic [7:0] shadow_frame [rpfsd_pkg::FRAME_BYTES];
  logic       link_up;
  logic [1:0] frame_phase;

  // Results still owed by the block, oldest first.
  rpfsd_pkg::out_word_t pending_words [$];
  rpfsd_pkg::out_word_t oldest_word;

  int         error_count   = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         words_sent    = 0;
  int         recent_row    = 0;
  logic [7:0] packet_body [rpfsd_pkg::ROW_BYTES];

  // The clock runs with a period of 10: five units low, then five high.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result word that one input word causes and moves the shadow state on.
  function automatic rpfsd_pkg::out_word_t predict_word(rpfsd_pkg::in_word_t w);
    rpfsd_pkg::out_word_t r;
    int                   base;
    int                   idx;
    logic [7:0]           v;
    logic [1:0]           grey;
    r = '0;
    case (w.mode)
      rpfsd_pkg::MODE_RX: begin
        // A wrong second byte sends the hunt back to the start, and that same byte is
        // then judged again as a possible start byte.
        if (rx_position == 1 && w.rx_byte != rpfsd_pkg::SECOND_BYTE) rx_position = 0;
        if (rx_position != 0 || w.rx_byte == rpfsd_pkg::START_BYTE) begin
          if (rx_position == 2) begin
            held_row = w.rx_byte;
          end else if (rx_position >= rpfsd_pkg::HEADER_BYTES &&
                       rx_position - rpfsd_pkg::HEADER_BYTES < rpfsd_pkg::ROW_BYTES) begin
            staged_row[rx_position - rpfsd_pkg::HEADER_BYTES] = w.rx_byte;
          end
          rx_position++;
          if (rx_position == rpfsd_pkg::PACKET_BYTES) begin
            rx_position = 0;
            link_up     = 1'b1;
            // A row that would start past the last row lands on row 0 instead.
            base = int'(held_row) * rpfsd_pkg::ROW_BYTES;
            if (base > rpfsd_pkg::LAST_ROW_START) base = 0;
            for (int i = 0; i < rpfsd_pkg::ROW_BYTES; i++) begin
              if (base + i < rpfsd_pkg::FRAME_BYTES) shadow_frame[base + i] = staged_row[i];
            end
            r.row_done    = 1'b1;
            r.row_written = 6'(base / rpfsd_pkg::ROW_BYTES);
          end
        end
      end
      rpfsd_pkg::MODE_SCAN: begin
        idx = int'(w.scan_index);
        if (idx < rpfsd_pkg::FRAME_BYTES) begin
          v = shadow_frame[idx];
          // Each 2-bit grey level maps to a dark dot: black always, dark grey on two
          // phases out of three, light grey on one, white never.
          for (int i = 0; i < 4; i++) begin
            grey = v[7 - 2 * i -: 2];
            case (grey)
              2'b00:   r.dots[i] = 1'b1;
              2'b10:   r.dots[i] = (frame_phase != 2'd0);
              2'b01:   r.dots[i] = (frame_phase == 2'd0);
              default: r.dots[i] = 1'b0;
            endcase
          end
        end
        r.pixel_x = 6'((idx % rpfsd_pkg::ROW_BYTES) * 4);
        r.pixel_y = 6'(idx / rpfsd_pkg::ROW_BYTES);
      end
      rpfsd_pkg::MODE_FRAME: begin
        frame_phase = (frame_phase == rpfsd_pkg::PHASE_LAST) ? 2'd0 : frame_phase + 2'd1;
      end
      default: begin
      end
    endcase
    r.linked = link_up;
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Both channels are watched at the rising edge. An accepted input word is predicted
  // first, then an accepted result word is held against the oldest prediction, so the
  // order of the two within one edge never matters. During reset the shadow state is set to
  // what the block reads back after its own reset.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_position = 0;
      held_row    = '0;
      link_up     = 1'b0;
      frame_phase = 2'd0;
      for (int i = 0; i < rpfsd_pkg::ROW_BYTES; i++) staged_row[i] = '0;
      for (int i = 0; i < rpfsd_pkg::FRAME_BYTES; i++) begin
        shadow_frame[i] = rpfsd_pkg::ERASED_BYTE;
      end
      pending_words.delete();
    end else begin
      if (in_valid && in_ready) pending_words.push_back(predict_word(in_data));
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          report_error("result word arrived with nothing pending");
        end else begin
          oldest_word = pending_words.pop_front();
          check_field("dots", 32'(out_data.dots), 32'(oldest_word.dots));
          check_field("pixel_x", 32'(out_data.pixel_x), 32'(oldest_word.pixel_x));
          check_field("pixel_y", 32'(out_data.pixel_y), 32'(oldest_word.pixel_y));
          check_field("linked", 32'(out_data.linked), 32'(oldest_word.linked));
          check_field("row_done", 32'(out_data.row_done), 32'(oldest_word.row_done));
          check_field("row_written", 32'(out_data.row_written),
                      32'(oldest_word.row_written));
        end
      end
    end
  end

  // The receiver decides at every falling edge whether it takes a word at the next
  // rising edge; with stall_pct at zero it never stalls.
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= stall_pct);
  end

  // Offers one word, after a random number of idle cycles, and holds it steady until it
  // is taken. The task returns at a falling edge with valid still high, so a following
  // word can go out back to back; valid drops only in the idle gaps and in wait_drain.
  task automatic send_word(rpfsd_pkg::in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // The unused fields of every word carry random values; the block must ignore them.
  task automatic send_rx(logic [7:0] b);
    send_word('{mode: rpfsd_pkg::MODE_RX, rx_byte: b,
                scan_index: 10'($urandom_range(0, 1023))});
  endtask

  task automatic send_scan(int idx);
    send_word('{mode: rpfsd_pkg::MODE_SCAN, rx_byte: 8'($urandom_range(0, 255)),
                scan_index: 10'(idx)});
  endtask

  task automatic send_other(logic [1:0] mode);
    send_word('{mode: mode, rx_byte: 8'($urandom_range(0, 255)),
                scan_index: 10'($urandom_range(0, 1023))});
  endtask

  // Scans lean toward the row written last, so that fresh pixel data is read back.
  function automatic int pick_scan_index();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return recent_row * rpfsd_pkg::ROW_BYTES +
             $urandom_range(0, rpfsd_pkg::ROW_BYTES - 1);
    end
    if (pick < 53) return 0;
    if (pick < 56) return rpfsd_pkg::FRAME_BYTES - 1;
    return $urandom_range(0, rpfsd_pkg::FRAME_BYTES - 1);
  endfunction

  // Sends a complete packet for the given row with the pixel bytes in packet_body.
  // Scans may be slipped in between pixel bytes; they must not disturb the deframer.
  task automatic send_row_packet(logic [7:0] row, int mix_pct);
    send_rx(rpfsd_pkg::START_BYTE);
    send_rx(rpfsd_pkg::SECOND_BYTE);
    send_rx(row);
    for (int i = 0; i < rpfsd_pkg::ROW_BYTES; i++) begin
      if ($urandom_range(0, 99) < mix_pct) send_scan(pick_scan_index());
      send_rx(packet_body[i]);
    end
    recent_row = (int'(row) * rpfsd_pkg::ROW_BYTES > rpfsd_pkg::LAST_ROW_START) ?
                 0 : int'(row);
  endtask

  // Lowers valid and waits until every predicted result has come back, then a little
  // longer so that a stray extra result would still be caught.
  task automatic wait_drain();
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed packets with random content and random rows, mixed with scans,
  // frame ends, the unused mode, broken headers, packets cut short and stray bytes.
  task automatic run_random_traffic(int count);
    int         target;
    int         pick;
    int         row;
    logic [7:0] b;
    target = words_sent + count;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        for (int i = 0; i < rpfsd_pkg::ROW_BYTES; i++) begin
          packet_body[i] = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) row = rpfsd_pkg::LAST_ROW;
        else if (pick == 1) row = rpfsd_pkg::LAST_ROW + 1;
        else if (pick < 4) row = $urandom_range(rpfsd_pkg::LAST_ROW + 1, 255);
        else row = $urandom_range(0, rpfsd_pkg::LAST_ROW);
        send_row_packet(8'(row), 10);
      end else if (pick < 66) begin
        send_rx(rpfsd_pkg::START_BYTE);
        if ($urandom_range(0, 1) == 0) begin
          // Wrong second byte; half the time that byte is itself a start byte.
          b = ($urandom_range(0, 1) == 0) ? rpfsd_pkg::START_BYTE :
              8'($urandom_range(0, 255));
          if (b == rpfsd_pkg::SECOND_BYTE) b = 8'h00;
          send_rx(b);
        end else begin
          // Start and second byte followed by only part of the rest of the packet.
          send_rx(rpfsd_pkg::SECOND_BYTE);
          repeat ($urandom_range(0, rpfsd_pkg::ROW_BYTES)) begin
            send_rx(8'($urandom_range(0, 255)));
          end
        end
      end else if (pick < 84) begin
        send_scan(pick_scan_index());
      end else if (pick < 92) begin
        send_other(rpfsd_pkg::MODE_FRAME);
      end else if (pick < 95) begin
        send_other(MODE_UNUSED);
      end else begin
        send_rx(8'($urandom_range(0, 255)));
      end
    end
    wait_drain();
  endtask

  // Before any packet the store reads as all white, so scans give no dots, and the
  // link flag stays low. The extremes of the index are covered here.
  task automatic test_unwritten_scan();
    send_scan(0);
    send_scan(rpfsd_pkg::FRAME_BYTES - 1);
    send_rx(rpfsd_pkg::SECOND_BYTE);
    send_other(MODE_UNUSED);
    wait_drain();
  endtask

  // A start byte followed by a wrong second byte, then a start byte followed by another
  // start byte, which must be taken as the beginning of the real packet. The row number
  // 255 lies past the end of the store and has to land on row 0. The pixel bytes cover
  // all four grey levels and include the framing bytes as plain data.
  task automatic test_resync_and_row_wrap();
    packet_body = '{8'h00, 8'h55, 8'hAA, 8'hFF, 8'h1B, 8'hE4,
                    rpfsd_pkg::START_BYTE, rpfsd_pkg::SECOND_BYTE,
                    8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h5A, 8'hA5, 8'h01, 8'h80};
    send_rx(rpfsd_pkg::START_BYTE);
    send_rx(8'h00);
    send_rx(rpfsd_pkg::START_BYTE);
    send_row_packet(8'hFF, 0);
    wait_drain();
  endtask

  // Reads a byte with all four grey levels through each dither phase and past the wrap
  // back to phase 0, then the last byte of the row for the largest pixel_x.
  task automatic test_dither_cycle();
    send_scan(4);
    repeat (3) begin
      send_other(rpfsd_pkg::MODE_FRAME);
      send_scan(4);
    end
    send_scan(rpfsd_pkg::ROW_BYTES - 1);
    wait_drain();
  endtask

  task automatic test_free_flow();
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_traffic(RANDOM_WORDS_PER_PHASE);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 60;
    stall_pct     = 0;
    run_random_traffic(RANDOM_WORDS_PER_PHASE);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct     = 60;
    run_random_traffic(RANDOM_WORDS_PER_PHASE);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 32;
    stall_pct     = 32;
    run_random_traffic(RANDOM_WORDS_PER_PHASE);
  endtask

  // Reset is held low from time 0 and released at a falling edge; every input is
  // at a known value from time 0.
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_unwritten_scan();
    test_resync_and_row_wrap();
    test_dither_cycle();
    test_free_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // A watchdog that ends a hung run and reports it as an error.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
